### rtl/core/ltri_pkg.sv
package ltri_pkg;

    typedef enum logic [1:0] {
        OC_HIT,
        OC_MISS,
        OC_BACK,
        OC_OUTSIDE
    } t_outcome;

endpackage

### rtl/core/ltri_in_if.sv
interface ltri_in_if #(
    parameter int W = 48
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] tri_a;
    logic [W-1:0] tri_b;
    logic [W-1:0] tri_c;
    logic [W-1:0] line_start;
    logic [W-1:0] line_end;

    modport source (output valid, tri_a, tri_b, tri_c, line_start, line_end, input ready);
    modport sink (input valid, tri_a, tri_b, tri_c, line_start, line_end, output ready);
endinterface

### rtl/core/ltri_cfg_if.sv
interface ltri_cfg_if ();
    logic valid;
    logic ready;
    logic plane_only;

    modport source (output valid, plane_only, input ready);
    modport sink (input valid, plane_only, output ready);
endinterface

### rtl/core/ltri_out_if.sv
interface ltri_out_if #(
    parameter int W = 48
) ();
    logic         valid;
    logic         ready;
    logic         hit;
    logic [1:0]   outcome;
    logic [W-1:0] hit_position;

    modport source (output valid, hit, outcome, hit_position, input ready);
    modport sink (input valid, hit, outcome, hit_position, output ready);
endinterface

### rtl/core/line_triangle_intersect.sv
// Channel  Dir  Payload                                              Handshake
// i_in     in   tri_a, tri_b, tri_c, line_start, line_end (3*CB b)  valid/ready
// i_cfg    in   plane_only (1 b)                                     valid/ready, always ready
// o_out    out  hit, outcome (2 b), hit_position (3*CB b)            valid/ready
//
// One item per cycle while o_out is not stalled. The pipeline depth grows with COORD_BITS through the
// divider, which retires one quotient bit per stage.
// Synchronous active-low reset clears the stage valid bits and plane_only.
// When a result waits and o_out.ready is low, the whole pipeline holds.
module line_triangle_intersect #(
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ltri_in_if.sink    i_in,
    ltri_cfg_if.sink   i_cfg,
    ltri_out_if.source o_out
);
    import ltri_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int D  = CB + 1;
    localparam int NW = 2 * D + 1;
    localparam int PW = D + NW;
    localparam int DW = 3 * D + 4;
    localparam int XW = 2 * NW;

    typedef struct packed {
        logic [2:0][CB-1:0] a;
        logic [2:0][CB-1:0] b;
        logic [2:0][CB-1:0] c;
        logic [2:0][CB-1:0] p;
        logic [2:0][NW-1:0] n;
        t_outcome           oc;
        logic [2:0]         neg;
    } t_ctx;

    localparam int CW = $bits(t_ctx);

    function automatic logic [D-1:0] f_dif(input logic [CB-1:0] x, input logic [CB-1:0] y);
        return D'($signed(x)) - D'($signed(y));
    endfunction

    logic en;
    logic r_plane_only;
    logic r_out_v;

    assign en          = !r_out_v || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_only <= 1'b0;
        end else if (i_cfg.valid) begin
            r_plane_only <= i_cfg.plane_only;
        end
    end

    // stage 1: unpack, edge and offset vectors
    logic [2:0][CB-1:0] u_a, u_b, u_c, u_p, u_q;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u_a[k] = i_in.tri_a[k*CB +: CB];
            u_b[k] = i_in.tri_b[k*CB +: CB];
            u_c[k] = i_in.tri_c[k*CB +: CB];
            u_p[k] = i_in.line_start[k*CB +: CB];
            u_q[k] = i_in.line_end[k*CB +: CB];
        end
    end

    logic               r1_v;
    t_ctx               r1_c;
    logic [2:0][D-1:0]  r1_e1, r1_e2, r1_pa, r1_qa, r1_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c.a   <= u_a;
            r1_c.b   <= u_b;
            r1_c.c   <= u_c;
            r1_c.p   <= u_p;
            r1_c.n   <= '0;
            r1_c.oc  <= OC_HIT;
            r1_c.neg <= '0;
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= f_dif(u_b[k], u_a[k]);
                r1_e2[k] <= f_dif(u_c[k], u_a[k]);
                r1_pa[k] <= f_dif(u_p[k], u_a[k]);
                r1_qa[k] <= f_dif(u_q[k], u_a[k]);
                r1_sp[k] <= f_dif(u_q[k], u_p[k]);
            end
        end
    end

    // stage 2: normal cross-product terms
    logic                 r2_v;
    t_ctx                 r2_c;
    logic [5:0][2*D-1:0]  r2_cp;
    logic [2:0][D-1:0]    r2_pa, r2_qa, r2_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c     <= r1_c;
            r2_pa    <= r1_pa;
            r2_qa    <= r1_qa;
            r2_sp    <= r1_sp;
            r2_cp[0] <= $signed(r1_e1[1]) * $signed(r1_e2[2]);
            r2_cp[1] <= $signed(r1_e1[2]) * $signed(r1_e2[1]);
            r2_cp[2] <= $signed(r1_e1[2]) * $signed(r1_e2[0]);
            r2_cp[3] <= $signed(r1_e1[0]) * $signed(r1_e2[2]);
            r2_cp[4] <= $signed(r1_e1[0]) * $signed(r1_e2[1]);
            r2_cp[5] <= $signed(r1_e1[1]) * $signed(r1_e2[0]);
        end
    end

    // stage 3: normal
    logic               r3_v;
    t_ctx               r3_c;
    t_ctx               n3_c;
    logic [2:0][D-1:0]  r3_pa, r3_qa, r3_sp;

    always_comb begin
        n3_c = r2_c;
        for (int k = 0; k < 3; k++) begin
            n3_c.n[k] = NW'($signed(r2_cp[2*k])) - NW'($signed(r2_cp[2*k+1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_c  <= n3_c;
            r3_pa <= r2_pa;
            r3_qa <= r2_qa;
            r3_sp <= r2_sp;
        end
    end

    // stage 4: plane distance terms
    logic               r4_v;
    t_ctx               r4_c;
    logic [2:0][PW-1:0] r4_pd, r4_qd;
    logic [2:0][D-1:0]  r4_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_c  <= r3_c;
            r4_sp <= r3_sp;
            for (int k = 0; k < 3; k++) begin
                r4_pd[k] <= $signed(r3_pa[k]) * $signed(r3_c.n[k]);
                r4_qd[k] <= $signed(r3_qa[k]) * $signed(r3_c.n[k]);
            end
        end
    end

    // stage 5: d1, d2
    logic               r5_v;
    t_ctx               r5_c;
    logic [DW-2:0]      r5_d1, r5_d2;
    logic [2:0][D-1:0]  r5_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_c  <= r4_c;
            r5_sp <= r4_sp;
            r5_d1 <= (DW-1)'($signed(r4_pd[0])) + (DW-1)'($signed(r4_pd[1]))
                   + (DW-1)'($signed(r4_pd[2]));
            r5_d2 <= (DW-1)'($signed(r4_qd[0])) + (DW-1)'($signed(r4_qd[1]))
                   + (DW-1)'($signed(r4_qd[2]));
        end
    end

    // stage 6: num, den, span magnitudes
    logic               r6_v;
    t_ctx               r6_c;
    t_ctx               n6_c;
    logic [DW-1:0]      r6_num, r6_den;
    logic [2:0][CB-1:0] r6_mag;

    always_comb begin
        n6_c = r5_c;
        for (int k = 0; k < 3; k++) begin
            n6_c.neg[k] = r5_sp[k][D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_c   <= n6_c;
            r6_num <= DW'(0) - DW'($signed(r5_d1));
            r6_den <= DW'($signed(r5_d2)) - DW'($signed(r5_d1));
            for (int k = 0; k < 3; k++) begin
                r6_mag[k] <= r5_sp[k][D-1] ? CB'(D'(0) - r5_sp[k]) : CB'(r5_sp[k]);
            end
        end
    end

    // stage 7: classify the crossing
    t_outcome n7_oc;
    t_ctx     n7_c;
    always_comb begin
        n7_oc = OC_HIT;
        if (r6_den == '0) begin
            n7_oc = OC_MISS;
        end else if (!r6_den[DW-1]) begin
            if (r6_num[DW-1] || ($signed(r6_num) > $signed(r6_den))) begin
                n7_oc = OC_MISS;
            end
        end else begin
            if ((!r6_num[DW-1] && r6_num != '0) || ($signed(r6_num) < $signed(r6_den))) begin
                n7_oc = OC_MISS;
            end else begin
                n7_oc = OC_BACK;
            end
        end
        n7_c    = r6_c;
        n7_c.oc = n7_oc;
    end

    logic               r7_v;
    t_ctx               r7_c;
    logic [DW-1:0]      r7_num, r7_den;
    logic [2:0][CB-1:0] r7_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_c    <= n7_c;
            r7_num  <= r6_num;
            r7_den  <= r6_den;
            r7_mag  <= r6_mag;
        end
    end

    // crossing fraction per coordinate
    logic               dv_v;
    logic [2:0][CB-1:0] dv_q;
    logic [CW-1:0]      dv_ctx;
    t_ctx               dv_c;

    ltri_div #(
        .CB (CB),
        .DW (DW),
        .CW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_mag   (r7_mag),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_ctx   (r7_c),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_ctx   (dv_ctx)
    );

    assign dv_c = t_ctx'(dv_ctx);

    // stage 8: crossing point, low bits only, it lies between P and Q
    logic               r8_v;
    t_ctx               r8_c;
    logic [2:0][CB-1:0] r8_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_c <= dv_c;
            for (int k = 0; k < 3; k++) begin
                r8_i[k] <= dv_c.p[k] + (dv_c.neg[k] ? (CB'(0) - dv_q[k]) : dv_q[k]);
            end
        end
    end

    // stage 9: edge vectors and point offsets (A->B, B->C, C->A)
    logic                   r9_v;
    t_ctx                   r9_c;
    logic [2:0][CB-1:0]     r9_i;
    logic [2:0][2:0][D-1:0] r9_ev, r9_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_c <= r8_c;
            r9_i <= r8_i;
            for (int k = 0; k < 3; k++) begin
                r9_ev[0][k] <= f_dif(r8_c.b[k], r8_c.a[k]);
                r9_ev[1][k] <= f_dif(r8_c.c[k], r8_c.b[k]);
                r9_ev[2][k] <= f_dif(r8_c.a[k], r8_c.c[k]);
                r9_x[0][k]  <= f_dif(r8_i[k], r8_c.a[k]);
                r9_x[1][k]  <= f_dif(r8_i[k], r8_c.b[k]);
                r9_x[2][k]  <= f_dif(r8_i[k], r8_c.c[k]);
            end
        end
    end

    // stage 10: edge x offset terms; (n x e).x equals n.(e x x)
    logic                     r10_v;
    t_ctx                     r10_c;
    logic [2:0][CB-1:0]       r10_i;
    logic [2:0][5:0][2*D-1:0] r10_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_c <= r9_c;
            r10_i <= r9_i;
            for (int e = 0; e < 3; e++) begin
                r10_cp[e][0] <= $signed(r9_ev[e][1]) * $signed(r9_x[e][2]);
                r10_cp[e][1] <= $signed(r9_ev[e][2]) * $signed(r9_x[e][1]);
                r10_cp[e][2] <= $signed(r9_ev[e][2]) * $signed(r9_x[e][0]);
                r10_cp[e][3] <= $signed(r9_ev[e][0]) * $signed(r9_x[e][2]);
                r10_cp[e][4] <= $signed(r9_ev[e][0]) * $signed(r9_x[e][1]);
                r10_cp[e][5] <= $signed(r9_ev[e][1]) * $signed(r9_x[e][0]);
            end
        end
    end

    // stage 11
    logic                    r11_v;
    t_ctx                    r11_c;
    logic [2:0][CB-1:0]      r11_i;
    logic [2:0][2:0][NW-1:0] r11_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (en) begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_c <= r10_c;
            r11_i <= r10_i;
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r11_w[e][k] <= NW'($signed(r10_cp[e][2*k])) - NW'($signed(r10_cp[e][2*k+1]));
                end
            end
        end
    end

    // stage 12
    logic                    r12_v;
    t_outcome                r12_oc;
    logic [2:0][CB-1:0]      r12_i;
    logic [2:0][2:0][XW-1:0] r12_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else if (en) begin
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_oc <= r11_c.oc;
            r12_i  <= r11_i;
            for (int e = 0; e < 3; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r12_t[e][k] <= $signed(r11_c.n[k]) * $signed(r11_w[e][k]);
                end
            end
        end
    end

    // output stage: edge signs and final outcome
    logic [2:0][XW+1:0] s_edge;
    logic               in_tri;
    t_outcome           n_oc;

    always_comb begin
        in_tri = 1'b1;
        for (int e = 0; e < 3; e++) begin
            s_edge[e] = (XW+2)'($signed(r12_t[e][0])) + (XW+2)'($signed(r12_t[e][1]))
                      + (XW+2)'($signed(r12_t[e][2]));
            if (s_edge[e][XW+1]) begin
                in_tri = 1'b0;
            end
        end
        n_oc = r12_oc;
        if (r12_oc == OC_HIT && !r_plane_only && !in_tri) begin
            n_oc = OC_OUTSIDE;
        end
    end

    logic            r_hit;
    t_outcome        r_oc;
    logic [3*CB-1:0] r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oc  <= n_oc;
            r_hit <= (n_oc == OC_HIT);
            r_pos <= (n_oc == OC_HIT) ? r12_i : '0;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.hit          = r_hit;
    assign o_out.outcome      = r_oc;
    assign o_out.hit_position = r_pos;

    a_hit_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hit == (o_out.outcome == OC_HIT)))
        else $error("hit flag disagrees with outcome");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.outcome != OC_HIT |-> o_out.hit_position == '0)
        else $error("position not cleared on miss");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !o_out.ready |-> !i_in.ready)
        else $error("input taken while pipeline is stalled");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_v && r7_c.oc == OC_HIT |-> !r7_den[DW-1] && r7_den != '0)
        else $error("front crossing with nonpositive denominator");

    a_div_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r7_v && r7_c.oc == OC_HIT |-> r7_num <= r7_den)
        else $error("crossing fraction above one");

endmodule

### rtl/core/ltri_div.sv
// Pipelined scaled division, three lanes: quo = floor(mag * num / den),
// one bit of mag per stage. Valid only for 0 <= num <= den, den > 0.
module ltri_div #(
    parameter int CB = 16,
    parameter int DW = 55,
    parameter int CW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2:0][CB-1:0]   i_mag,
    input  logic [DW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    input  logic [CW-1:0]        i_ctx,
    output logic                 o_valid,
    output logic [2:0][CB-1:0]   o_quo,
    output logic [CW-1:0]        o_ctx
);

    logic                 r_v   [1:CB];
    logic [2:0][DW-1:0]   r_rem [1:CB];
    logic [2:0][CB-1:0]   r_q   [1:CB];
    logic [2:0][CB-1:0]   r_mag [1:CB];
    logic [DW-1:0]        r_num [1:CB];
    logic [DW-1:0]        r_den [1:CB];
    logic [CW-1:0]        r_ctx [1:CB];

    for (genvar s = 0; s < CB; s++) begin : g_st
        logic               s_v;
        logic [2:0][DW-1:0] s_rem;
        logic [2:0][CB-1:0] s_q;
        logic [2:0][CB-1:0] s_mag;
        logic [DW-1:0]      s_num;
        logic [DW-1:0]      s_den;
        logic [CW-1:0]      s_ctx;
        logic [2:0][DW-1:0] n_rem;
        logic [2:0][CB-1:0] n_q;

        if (s == 0) begin : g_head
            assign s_v   = i_valid;
            assign s_rem = '0;
            assign s_q   = '0;
            assign s_mag = i_mag;
            assign s_num = i_num;
            assign s_den = i_den;
            assign s_ctx = i_ctx;
        end else begin : g_tail
            assign s_v   = r_v[s];
            assign s_rem = r_rem[s];
            assign s_q   = r_q[s];
            assign s_mag = r_mag[s];
            assign s_num = r_num[s];
            assign s_den = r_den[s];
            assign s_ctx = r_ctx[s];
        end

        // remainder stays below den, so the new digit is 0, 1 or 2
        always_comb begin
            logic [DW+1:0] t;
            logic [DW+1:0] d1;
            logic [DW+1:0] d2;
            d1 = {2'b00, s_den};
            d2 = {1'b0, s_den, 1'b0};
            for (int l = 0; l < 3; l++) begin
                t = {1'b0, s_rem[l], 1'b0} + (s_mag[l][CB-1-s] ? {2'b00, s_num} : '0);
                if (t >= d2) begin
                    n_rem[l] = DW'(t - d2);
                    n_q[l]   = (s_q[l] << 1) + CB'(2);
                end else if (t >= d1) begin
                    n_rem[l] = DW'(t - d1);
                    n_q[l]   = (s_q[l] << 1) + CB'(1);
                end else begin
                    n_rem[l] = DW'(t);
                    n_q[l]   = s_q[l] << 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
                r_mag[s+1] <= s_mag;
                r_num[s+1] <= s_num;
                r_den[s+1] <= s_den;
                r_ctx[s+1] <= s_ctx;
            end
        end
    end

    assign o_valid = r_v[CB];
    assign o_quo   = r_q[CB];
    assign o_ctx   = r_ctx[CB];

endmodule
